### rtl/core/batched_matrix_vector_multiply_defines.svh
// Assertion macros for the batched matrix-vector multiply RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef BATCHED_MATRIX_VECTOR_MULTIPLY_DEFINES_SVH
`define BATCHED_MATRIX_VECTOR_MULTIPLY_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define BMV_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("bmv assertion failed");

// Check that a trigger is followed by a condition in the next cycle.
`define BMV_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("bmv assertion failed");

`endif

### rtl/core/bmv_pkg.sv
// Shared types, codes and a helper function for the batched matrix-vector multiply.
// No dependencies.
`timescale 1ns / 1ps

package bmv_pkg;

  // Input word opcodes
  localparam logic [1:0] OP_LOAD_MATRIX = 2'd0;
  localparam logic [1:0] OP_LOAD_VECTOR = 2'd1;
  localparam logic [1:0] OP_COMPUTE     = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_INPUT_LENGTH  = 2'd0;
  localparam logic [1:0] CFG_OUTPUT_LENGTH = 2'd1;
  localparam logic [1:0] CFG_BATCH_COUNT   = 2'd2;
  localparam logic [1:0] CFG_LAYOUT        = 2'd3;

  // Layout variants
  localparam logic [2:0] LAY_ROW_BATCH   = 3'd0;
  localparam logic [2:0] LAY_ROW_OUTBAT  = 3'd1;
  localparam logic [2:0] LAY_COL_MATRIX  = 3'd2;
  localparam logic [2:0] LAY_ELEM_INPUT  = 3'd3;
  localparam logic [2:0] LAY_ELEM_OUTBAT = 3'd4;

  // Canonical quiet NaN
  localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;

  // Controller to datapath commands
  typedef struct packed {
    logic start;   // latch compute item, clear accumulator
    logic step;    // read one element pair
    logic emit;    // move accumulator into output register
    logic wr_m;    // write matrix store
    logic wr_v;    // write vector store
  } bmv_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic       in_range;  // compute item row and column inside sizes
    logic       done;      // accumulate of one pair finished
    logic       out_busy;  // output register full and not taken
    logic [6:0] ni;        // effective input length
  } bmv_status_t;

  // Count leading zeros of a 48-bit word, 48 for zero
  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    n = 6'd48;
    for (int k = 0; k < 48; k++) begin
      if (v[k]) n = 6'(47 - k);
    end
    return n;
  endfunction

endpackage

### rtl/core/bmv_fmul.sv
// Three-stage IEEE single multiplier, round to nearest even, subnormals kept.
// Depends on bmv_pkg.
`timescale 1ns / 1ps

module bmv_fmul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] p_o
);
  import bmv_pkg::*;

  // Stage 1: unpack and multiply significands
  logic [23:0] ma, mb;
  logic [8:0]  eea, eeb;
  logic        nan_a, nan_b, inf_a, inf_b, zer_a, zer_b;
  logic [47:0] s1_p_q;
  logic [9:0]  s1_e_q;
  logic        s1_sgn_q, s1_nan_q, s1_inf_q, s1_zer_q;

  always_comb begin
    ma    = {a_i[30:23] != 8'd0, a_i[22:0]};
    mb    = {b_i[30:23] != 8'd0, b_i[22:0]};
    eea   = (a_i[30:23] == 8'd0) ? 9'd1 : {1'b0, a_i[30:23]};
    eeb   = (b_i[30:23] == 8'd0) ? 9'd1 : {1'b0, b_i[30:23]};
    nan_a = (a_i[30:23] == 8'hFF) && (a_i[22:0] != 23'd0);
    nan_b = (b_i[30:23] == 8'hFF) && (b_i[22:0] != 23'd0);
    inf_a = (a_i[30:23] == 8'hFF) && (a_i[22:0] == 23'd0);
    inf_b = (b_i[30:23] == 8'hFF) && (b_i[22:0] == 23'd0);
    zer_a = (a_i[30:0] == 31'd0);
    zer_b = (b_i[30:0] == 31'd0);
  end

  always_ff @(posedge clk_i) begin
    s1_p_q   <= ma * mb;
    s1_e_q   <= {1'b0, eea} + {1'b0, eeb};
    s1_sgn_q <= a_i[31] ^ b_i[31];
    s1_nan_q <= nan_a | nan_b | (inf_a & zer_b) | (zer_a & inf_b);
    s1_inf_q <= inf_a | inf_b;
    s1_zer_q <= zer_a | zer_b;
  end

  // Stage 2: normalize so the leading one sits at bit 47
  logic [5:0]         lz;
  logic [47:0]        s2_p_q;
  logic signed [10:0] s2_e_q;
  logic               s2_sgn_q, s2_nan_q, s2_inf_q, s2_zer_q;

  assign lz = lzc48(s1_p_q);

  always_ff @(posedge clk_i) begin
    s2_p_q   <= s1_p_q << lz;
    s2_e_q   <= $signed({1'b0, s1_e_q}) - 11'sd126 - $signed({5'd0, lz});
    s2_sgn_q <= s1_sgn_q;
    s2_nan_q <= s1_nan_q;
    s2_inf_q <= s1_inf_q;
    s2_zer_q <= s1_zer_q;
  end

  // Stage 3: denormalize if needed, round and pack
  logic [10:0] shv;
  logic [5:0]  sh;
  logic [47:0] y;
  logic        lost;
  logic [7:0]  expf;
  logic [22:0] frac;
  logic        g, st, inc;
  logic [30:0] packed_w;
  logic [31:0] res;

  always_comb begin
    shv  = 11'd1 - s2_e_q;
    sh   = (s2_e_q >= 11'sd1) ? 6'd0 : ((shv > 11'd49) ? 6'd49 : shv[5:0]);
    y    = s2_p_q >> sh;
    lost = |(s2_p_q & ~({48{1'b1}} << sh));
    expf = (s2_e_q >= 11'sd1) ? s2_e_q[7:0] : 8'd0;
    frac = y[46:24];
    g    = y[23];
    st   = (|y[22:0]) | lost;
    inc  = g & (st | frac[0]);
    packed_w = {expf, frac} + {30'd0, inc};
    priority if (s2_nan_q) begin
      res = FP_QNAN;
    end else if (s2_inf_q || (s2_e_q >= 11'sd255)) begin
      res = {s2_sgn_q, 8'hFF, 23'd0};
    end else if (s2_zer_q) begin
      res = {s2_sgn_q, 31'd0};
    end else begin
      res = {s2_sgn_q, packed_w};
    end
  end

  always_ff @(posedge clk_i) begin
    p_o <= res;
  end

endmodule

### rtl/core/bmv_fadd.sv
// Three-stage IEEE single adder, round to nearest even, subnormals kept.
// Depends on bmv_pkg.
`timescale 1ns / 1ps

module bmv_fadd (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] s_o
);
  import bmv_pkg::*;

  // Stage 1: order by magnitude and align the smaller operand
  logic [31:0] x, y;
  logic [7:0]  ex, ey, d;
  logic [26:0] my27, ysh;
  logic        stk, nan_a, nan_b, inf_a, inf_b;
  logic [26:0] s1_mx_q, s1_my_q;
  logic [7:0]  s1_e_q;
  logic        s1_sx_q, s1_sub_q, s1_nan_q, s1_inf_q, s1_zs_q;

  always_comb begin
    if (a_i[30:0] >= b_i[30:0]) begin
      x = a_i;
      y = b_i;
    end else begin
      x = b_i;
      y = a_i;
    end
    ex    = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey    = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    d     = ex - ey;
    my27  = {y[30:23] != 8'd0, y[22:0], 3'b000};
    if (d >= 8'd27) begin
      ysh = 27'd0;
      stk = |my27;
    end else begin
      ysh = my27 >> d[4:0];
      stk = |(my27 & ~({27{1'b1}} << d[4:0]));
    end
    nan_a = (a_i[30:23] == 8'hFF) && (a_i[22:0] != 23'd0);
    nan_b = (b_i[30:23] == 8'hFF) && (b_i[22:0] != 23'd0);
    inf_a = (a_i[30:23] == 8'hFF) && (a_i[22:0] == 23'd0);
    inf_b = (b_i[30:23] == 8'hFF) && (b_i[22:0] == 23'd0);
  end

  always_ff @(posedge clk_i) begin
    s1_mx_q  <= {x[30:23] != 8'd0, x[22:0], 3'b000};
    s1_my_q  <= {ysh[26:1], ysh[0] | stk};
    s1_e_q   <= ex;
    s1_sx_q  <= x[31];
    s1_sub_q <= x[31] ^ y[31];
    s1_nan_q <= nan_a | nan_b | (inf_a & inf_b & (a_i[31] ^ b_i[31]));
    s1_inf_q <= inf_a | inf_b;
    s1_zs_q  <= a_i[31] & b_i[31];
  end

  // Stage 2: add or subtract, then normalize
  logic [27:0] sum;
  logic [5:0]  lz, lzl;
  logic [8:0]  emax;
  logic [26:0] s2_n_q;
  logic [8:0]  s2_e_q;
  logic        s2_zero_q, s2_sx_q, s2_nan_q, s2_inf_q, s2_zs_q;
  logic [26:0] n_d;
  logic [8:0]  e_d;

  always_comb begin
    sum  = s1_sub_q ? ({1'b0, s1_mx_q} - {1'b0, s1_my_q})
                    : ({1'b0, s1_mx_q} + {1'b0, s1_my_q});
    lz   = lzc48({sum[26:0], 21'd0});
    emax = {1'b0, s1_e_q} - 9'd1;
    lzl  = ({3'd0, lz} > emax) ? emax[5:0] : lz;
    if (sum[27]) begin
      n_d = {sum[27:2], sum[1] | sum[0]};
      e_d = {1'b0, s1_e_q} + 9'd1;
    end else begin
      n_d = sum[26:0] << lzl;
      e_d = {1'b0, s1_e_q} - {3'd0, lzl};
    end
  end

  always_ff @(posedge clk_i) begin
    s2_n_q    <= n_d;
    s2_e_q    <= e_d;
    s2_zero_q <= (sum == 28'd0);
    s2_sx_q   <= s1_sx_q;
    s2_nan_q  <= s1_nan_q;
    s2_inf_q  <= s1_inf_q;
    s2_zs_q   <= s1_zs_q;
  end

  // Stage 3: round and pack
  logic [7:0]  expf;
  logic        inc;
  logic [30:0] packed_w;
  logic [31:0] res;

  always_comb begin
    expf     = s2_n_q[26] ? s2_e_q[7:0] : 8'd0;
    inc      = s2_n_q[2] & (s2_n_q[1] | s2_n_q[0] | s2_n_q[3]);
    packed_w = {expf, s2_n_q[25:3]} + {30'd0, inc};
    priority if (s2_nan_q) begin
      res = FP_QNAN;
    end else if (s2_inf_q || (s2_e_q >= 9'd255)) begin
      res = {s2_sx_q, 8'hFF, 23'd0};
    end else if (s2_zero_q) begin
      res = {s2_zs_q, 31'd0};
    end else begin
      res = {s2_sx_q, packed_w};
    end
  end

  always_ff @(posedge clk_i) begin
    s_o <= res;
  end

endmodule

### rtl/core/bmv_ctrl.sv
// Controller state machine: accepts words, sequences element pairs, emits results.
// Depends on bmv_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "batched_matrix_vector_multiply_defines.svh"

module bmv_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           opcode_i,
  input  bmv_pkg::bmv_status_t status_i,
  output bmv_pkg::bmv_cmd_t    cmd_o
);
  import bmv_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_BUSY  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state_q, state_d;
  logic [6:0] cnt_q, cnt_d;
  logic       acc;

  assign in_ready_o = (state_q == ST_IDLE);
  assign acc        = in_valid_i & in_ready_o;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.wr_m = acc && (opcode_i == OP_LOAD_MATRIX);
        cmd_o.wr_v = acc && (opcode_i == OP_LOAD_VECTOR);
        if (acc && (opcode_i == OP_COMPUTE) && status_i.in_range) begin
          cmd_o.start = 1'b1;
          cnt_d       = 7'd0;
          state_d     = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 7'd1;
        state_d    = ST_BUSY;
      end
      ST_BUSY: begin
        if (status_i.done) begin
          state_d = (cnt_q == status_i.ni) ? ST_DONE : ST_ISSUE;
        end
      end
      ST_DONE: begin
        if (!status_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= 7'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  `BMV_ASSERT_NEXT(a_step_then_busy, cmd_o.step, state_q == ST_BUSY)
  `BMV_ASSERT(a_done_only_busy, !status_i.done || (state_q == ST_BUSY))
  `BMV_ASSERT(a_emit_free, !cmd_o.emit || !status_i.out_busy)
  `BMV_ASSERT(a_cnt_bound, (state_q != ST_BUSY) || ((cnt_q != 7'd0) && (cnt_q <= status_i.ni)))

endmodule

### rtl/core/bmv_dp.sv
// Datapath: configuration registers, matrix and vector stores, address walk,
// multiply-accumulate pipeline and output register. Depends on bmv_pkg and FP units.
`timescale 1ns / 1ps

module bmv_dp #(
  parameter int MAX_INPUT  = 64,
  parameter int MAX_OUTPUT = 64,
  parameter int MAX_BATCH  = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [6:0]           cfg_data_i,
  input  logic [11:0]          flat_address_i,
  input  logic [31:0]          load_value_i,
  input  logic [5:0]           output_row_i,
  input  logic [3:0]           batch_column_i,
  input  bmv_pkg::bmv_cmd_t    cmd_i,
  output bmv_pkg::bmv_status_t status_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [9:0]           result_position_o,
  output logic [31:0]          result_value_o
);
  import bmv_pkg::*;

  localparam int MDEPTH = MAX_INPUT * MAX_OUTPUT;
  localparam int VDEPTH = MAX_INPUT * MAX_BATCH;
  localparam int MAW    = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
  localparam int VAW    = (VDEPTH > 1) ? $clog2(VDEPTH) : 1;
  localparam int NI_MAX = (MAX_INPUT > 127) ? 127 : MAX_INPUT;
  localparam int NO_MAX = (MAX_OUTPUT > 127) ? 127 : MAX_OUTPUT;
  localparam int NB_MAX = (MAX_BATCH > 31) ? 31 : MAX_BATCH;

  // Configuration registers
  logic [6:0] in_len_q, out_len_q;
  logic [4:0] bat_q;
  logic [2:0] lay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_len_q  <= 7'd64;
      out_len_q <= 7'd64;
      bat_q     <= 5'd16;
      lay_q     <= LAY_ROW_BATCH;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_INPUT_LENGTH:  in_len_q  <= cfg_data_i;
        CFG_OUTPUT_LENGTH: out_len_q <= cfg_data_i;
        CFG_BATCH_COUNT:   bat_q     <= cfg_data_i[4:0];
        CFG_LAYOUT:        lay_q     <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // Effective sizes and layout
  logic [6:0] ni, no;
  logic [4:0] nb;
  logic [2:0] lay;
  logic       m_col, v_elem, o_bat;

  always_comb begin
    ni = (in_len_q == 7'd0) ? 7'd1 : ((in_len_q > 7'(NI_MAX)) ? 7'(NI_MAX) : in_len_q);
    no = (out_len_q == 7'd0) ? 7'd1 : ((out_len_q > 7'(NO_MAX)) ? 7'(NO_MAX) : out_len_q);
    nb = (bat_q == 5'd0) ? 5'd1 : ((bat_q > 5'(NB_MAX)) ? 5'(NB_MAX) : bat_q);
    lay    = (lay_q > LAY_ELEM_OUTBAT) ? LAY_ROW_BATCH : lay_q;
    m_col  = (lay == LAY_COL_MATRIX);
    v_elem = (lay == LAY_ELEM_INPUT) || (lay == LAY_ELEM_OUTBAT);
    o_bat  = (lay == LAY_ROW_OUTBAT) || (lay == LAY_ELEM_OUTBAT);
  end

  // Address walk registers
  logic [MAW-1:0] ma_q, mstep_q;
  logic [VAW-1:0] va_q, vstep_q;
  logic [9:0]     pos_q;
  logic [12:0]    o_ni;
  logic [10:0]    b_ni, b_no, o_nb;

  always_comb begin
    o_ni = {7'd0, output_row_i} * {6'd0, ni};
    b_ni = {7'd0, batch_column_i} * {4'd0, ni};
    b_no = {7'd0, batch_column_i} * {4'd0, no};
    o_nb = {5'd0, output_row_i} * {6'd0, nb};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      ma_q    <= m_col ? MAW'(output_row_i) : MAW'(o_ni);
      mstep_q <= m_col ? MAW'(no) : MAW'(1);
      va_q    <= v_elem ? VAW'(batch_column_i) : VAW'(b_ni);
      vstep_q <= v_elem ? VAW'(nb) : VAW'(1);
      pos_q   <= o_bat ? (b_no[9:0] + {4'd0, output_row_i})
                       : (o_nb[9:0] + {6'd0, batch_column_i});
    end else if (cmd_i.step) begin
      ma_q <= ma_q + mstep_q;
      va_q <= va_q + vstep_q;
    end
  end

  // Stores: written by load words, read one pair per step
  logic [31:0] mem_m [MDEPTH];
  logic [31:0] mem_v [VDEPTH];
  logic [31:0] rd_m_q, rd_v_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_m && ({20'd0, flat_address_i} < 32'(MDEPTH))) begin
      mem_m[MAW'(flat_address_i)] <= load_value_i;
    end
    if (cmd_i.step) begin
      rd_m_q <= mem_m[ma_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_v && ({20'd0, flat_address_i} < 32'(VDEPTH))) begin
      mem_v[VAW'(flat_address_i)] <= load_value_i;
    end
    if (cmd_i.step) begin
      rd_v_q <= mem_v[va_q];
    end
  end

  // Multiply-accumulate: read, three multiply stages, three add stages
  logic [31:0] prod, sum, acc_q;
  logic [6:0]  vld_q;

  bmv_fmul u_fmul (
    .clk_i (clk_i),
    .a_i   (rd_m_q),
    .b_i   (rd_v_q),
    .p_o   (prod)
  );

  bmv_fadd u_fadd (
    .clk_i (clk_i),
    .a_i   (acc_q),
    .b_i   (prod),
    .s_o   (sum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[5:0], cmd_i.step};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      acc_q <= 32'd0;
    end else if (vld_q[6]) begin
      acc_q <= sum;
    end
  end

  // Output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      result_position_o <= pos_q;
      result_value_o    <= ((acc_q[30:23] == 8'hFF) && (acc_q[22:0] != 23'd0)) ? FP_QNAN
                                                                               : acc_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.in_range = ({1'b0, output_row_i} < no) && ({1'b0, batch_column_i} < nb);
  assign status_o.done     = vld_q[6];
  assign status_o.out_busy = out_valid_q & ~out_ready_i;
  assign status_o.ni       = ni;

endmodule

### rtl/core/batched_matrix_vector_multiply.sv
// Batched float32 matrix-vector multiply. Load words go straight into the stores.
// A compute word walks its input elements in turn (issue, store read, three multiply
// stages, three add stages around the accumulator loop); no new word is accepted until
// its result moves into the output register, which waits while a result is not taken.
// Reset returns control state and configuration to defaults; stores are not cleared.
`timescale 1ns / 1ps

module batched_matrix_vector_multiply #(
  parameter int MAX_INPUT  = 64,
  parameter int MAX_OUTPUT = 64,
  parameter int MAX_BATCH  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [6:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // flat_address[11:0], load_value[43:12], output_row[49:44], batch_column[53:50]
  input  logic [55:0] s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // result_position[9:0], result_value[41:10]
  output logic [47:0] m_axis_tdata
);
  import bmv_pkg::*;

  bmv_cmd_t    cmd;
  bmv_status_t status;
  logic [9:0]  res_pos;
  logic [31:0] res_val;

  assign cfg_ready_o = 1'b1;

  bmv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .opcode_i   (s_axis_tuser),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bmv_dp #(
    .MAX_INPUT  (MAX_INPUT),
    .MAX_OUTPUT (MAX_OUTPUT),
    .MAX_BATCH  (MAX_BATCH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .flat_address_i    (s_axis_tdata[11:0]),
    .load_value_i      (s_axis_tdata[43:12]),
    .output_row_i      (s_axis_tdata[49:44]),
    .batch_column_i    (s_axis_tdata[53:50]),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .result_position_o (res_pos),
    .result_value_o    (res_val)
  );

  assign m_axis_tdata = {6'd0, res_val, res_pos};

endmodule
